FILE: hdl/sax_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sax_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_SEGMENT = 256;
  localparam int LEN_W       = 9;
  localparam int ALPHA_W     = 4;
  localparam int ALPHA_MAX   = 10;
  localparam int NUM_BP      = ALPHA_MAX - 1;
  localparam int SYM_W       = 4;
  localparam int SUM_W       = SAMPLE_W + LEN_W - 1;
  localparam int BP_W        = 14;
  localparam int PROD_W      = BP_W + LEN_W + 1;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [0:0] {
    REG_SEGMENT_LENGTH = 1'b0,
    REG_ALPHABET_SIZE  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       series_end;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } out_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [LEN_W-1:0]        count;
    logic                    last;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic signed [BP_W-1:0] bp_t;
  typedef bp_t bp_row_t [NUM_BP];

  // gaussian breakpoints in q2.12, one row per alphabet size
  localparam bp_row_t BP_TABLE [ALPHA_MAX+1] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{-1764, 1764, 0, 0, 0, 0, 0, 0, 0},
    '{-2763, 0, 2763, 0, 0, 0, 0, 0, 0},
    '{-3447, -1038, 1038, 3447, 0, 0, 0, 0, 0},
    '{-3963, -1764, 0, 1764, 3963, 0, 0, 0, 0},
    '{-4373, -2318, -737, 737, 2318, 4373, 0, 0, 0},
    '{-4712, -2763, -1305, 0, 1305, 2763, 4712, 0, 0},
    '{-5000, -3132, -1764, -572, 572, 1764, 3132, 5000, 0},
    '{-5249, -3447, -2148, -1038, 0, 1038, 2148, 3447, 5249}
  };

endpackage

`default_nettype wire

FILE: hdl/sax_symbol_encoder_top.sv
// channel  | handshake                  | payload
// sample   | sample_valid, sample_ready | sample_item (sample, series_end)
// symbol   | symbol_valid, symbol_ready | symbol_item (symbol, last_symbol)
// config   | psel, penable, pwrite      | paddr, pwdata, prdata
//
// one sample per cycle unless the queue is full; the front accumulator closes a segment in the cycle it is taken
// a symbol is offered once it has passed, from the edge that takes its closing sample:
// queue write, product stage, output register
// reset restores segment_length 8 and alphabet_size 4 and clears the running segment
// a four-entry segment queue decouples front and back; sample_ready drops only when it fills
`timescale 1ns / 1ps
`default_nettype none

module sax_symbol_encoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        sample_valid,
  output logic                             sample_ready,
  input  wire sax_pkg::in_t                sample_item,
  output logic                             symbol_valid,
  input  wire logic                        symbol_ready,
  output sax_pkg::out_t                    symbol_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sax_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sax_pkg::DATA_W-1:0]  pwdata,
  output logic [sax_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import sax_pkg::*;

  logic [LEN_W-1:0]   segment_length;
  logic [ALPHA_W-1:0] alphabet_size;
  reg_idx_t           reg_idx;
  logic               wr_en;

  logic               q_push;
  logic               q_pop;
  seg_t               q_wdata;
  seg_t               q_rdata;
  q_stat_t            q_stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_length <= LEN_W'(8);
      alphabet_size  <= ALPHA_W'(4);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SEGMENT_LENGTH: segment_length <= pwdata[LEN_W-1:0];
        REG_ALPHABET_SIZE:  alphabet_size  <= pwdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEGMENT_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, segment_length};
      REG_ALPHABET_SIZE:  prdata = {{(DATA_W-ALPHA_W){1'b0}}, alphabet_size};
      default:            prdata = '0;
    endcase
  end

  sax_front u_front (
    .clk            (clk),
    .rst            (rst),
    .valid          (sample_valid),
    .ready          (sample_ready),
    .item           (sample_item),
    .segment_length (segment_length),
    .q_full         (q_stat.full),
    .push           (q_push),
    .seg            (q_wdata)
  );

  sax_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  sax_back u_back (
    .clk           (clk),
    .rst           (rst),
    .alphabet_size (alphabet_size),
    .q_empty       (q_stat.empty),
    .q_data        (q_rdata),
    .pop           (q_pop),
    .valid         (symbol_valid),
    .ready         (symbol_ready),
    .item          (symbol_item)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full || q_pop)
    else $error("segment pushed into full queue");

  a_symbol_range: assert property (@(posedge clk) disable iff (rst)
    symbol_valid |-> symbol_item.symbol <= SYM_W'(NUM_BP))
    else $error("symbol above largest alphabet");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !symbol_valid && q_stat.empty)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: hdl/sax_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sax_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     valid,
  output logic                          ready,
  input  wire sax_pkg::in_t             item,
  input  wire logic [sax_pkg::LEN_W-1:0] segment_length,
  input  wire logic                     q_full,
  output logic                          push,
  output sax_pkg::seg_t                 seg
);
  import sax_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic [LEN_W-1:0]        count;
  logic signed [SUM_W-1:0] sum_next;
  logic [LEN_W-1:0]        count_next;
  logic [LEN_W-1:0]        len_eff;
  logic                    accept;
  logic                    close;

  always_comb begin
    if (segment_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (segment_length > LEN_W'(MAX_SEGMENT)) begin
      len_eff = LEN_W'(MAX_SEGMENT);
    end else begin
      len_eff = segment_length;
    end
  end

  assign ready      = !q_full;
  assign accept     = valid && ready;
  assign sum_next   = sum + {{(SUM_W-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample};
  assign count_next = count + LEN_W'(1);
  assign close      = (count_next >= len_eff) || item.series_end;
  assign push       = accept && close;

  assign seg.sum   = sum_next;
  assign seg.count = count_next;
  assign seg.last  = item.series_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (close) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sax_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sax_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sax_pkg::seg_t   wdata,
  input  wire logic            pop,
  output sax_pkg::seg_t        rdata,
  output sax_pkg::q_stat_t     stat
);
  import sax_pkg::*;

  seg_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign rdata      = entries[rd_ptr];
  assign stat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sax_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sax_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [sax_pkg::ALPHA_W-1:0] alphabet_size,
  input  wire logic                        q_empty,
  input  wire sax_pkg::seg_t               q_data,
  output logic                             pop,
  output logic                             valid,
  input  wire logic                        ready,
  output sax_pkg::out_t                    item
);
  import sax_pkg::*;

  logic [ALPHA_W-1:0]      a_eff;
  logic [ALPHA_W-1:0]      nbp;
  logic signed [PROD_W-1:0] prod_c [NUM_BP];
  logic [NUM_BP-1:0]       en_c;

  logic                    s1_valid;
  logic signed [SUM_W-1:0] s1_sum;
  logic signed [PROD_W-1:0] s1_prod [NUM_BP];
  logic [NUM_BP-1:0]       s1_en;
  logic                    s1_last;

  logic [SYM_W-1:0]        sym_c;
  logic                    o_adv;
  logic                    s1_adv;

  assign o_adv  = !valid || ready;
  assign s1_adv = !s1_valid || o_adv;
  assign pop    = !q_empty && s1_adv;

  always_comb begin
    if (alphabet_size > ALPHA_W'(ALPHA_MAX)) begin
      a_eff = ALPHA_W'(ALPHA_MAX);
    end else begin
      a_eff = alphabet_size;
    end
    nbp = (a_eff < ALPHA_W'(2)) ? '0 : a_eff - ALPHA_W'(1);
  end

  // breakpoint times the segment's sample count, one constant row per alphabet
  always_comb begin
    for (int i = 0; i < NUM_BP; i++) begin
      prod_c[i] = PROD_W'(BP_TABLE[a_eff][i]) * PROD_W'($signed({1'b0, q_data.count}));
      en_c[i]   = (ALPHA_W'(i) < nbp);
    end
  end

  always_comb begin
    sym_c = '0;
    for (int i = 0; i < NUM_BP; i++) begin
      if (s1_en[i] && (s1_sum > s1_prod[i])) begin
        sym_c = sym_c + SYM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_sum  <= q_data.sum;
      s1_en   <= en_c;
      s1_last <= q_data.last;
      for (int i = 0; i < NUM_BP; i++) begin
        s1_prod[i] <= prod_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (o_adv) begin
      valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && s1_valid) begin
      item.symbol      <= sym_c;
      item.last_symbol <= s1_last;
    end
  end

endmodule

`default_nettype wire
